@@ design/servo_pulse_sequencer_unit_macros.svh @@
// Assertion macros for the servo pulse sequencer.
`ifndef SERVO_PULSE_SEQUENCER_UNIT_MACROS_SVH
`define SERVO_PULSE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spsu assertion failed");

// Next-cycle implication, disabled during reset.
`define SPSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spsu assertion failed");

`endif

@@ design/spsu_pkg.sv @@
// Types and constants shared by the servo pulse sequencer modules.
`timescale 1ns / 1ps
package spsu_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } spsu_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] servo_lines;
    logic       channel_odd;
    logic       last;
  } spsu_out_t;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_ECHO,
    KIND_PROMPT
  } spsu_kind_t;

  typedef struct packed {
    spsu_kind_t  kind;
    logic [7:0]  echo_byte;
    logic [2:0]  active;
  } spsu_burst_t;

  typedef struct packed {
    logic               busy;
    logic signed [9:0]  step;
    logic [15:0]        mid;
  } spsu_scale_t;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] CFG_PULSE_MIN = 2'd0;
  localparam logic [1:0] CFG_PULSE_MAX = 2'd1;

  localparam logic [15:0] PULSE_MIN_RESET = 16'd780;
  localparam logic [15:0] PULSE_MAX_RESET = 16'd2200;

  localparam logic signed [7:0] ANGLE_STEP = 8'sd15;
  localparam logic signed [7:0] ANGLE_MAX  = 8'sd90;
  localparam logic signed [7:0] ANGLE_MIN  = -8'sd90;

  // ceil(2^23 / 180): exact quotient by 180 for any 16-bit dividend
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [15:0] RECIP_180   = 16'd46604;

  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_GT    = 8'h3E;

  localparam logic [1:0] BEAT_ECHO = 2'd0;
  localparam logic [1:0] BEAT_CR   = 2'd1;
  localparam logic [1:0] BEAT_LF   = 2'd2;
  localparam logic [1:0] BEAT_GT   = 2'd3;

endpackage

@@ design/servo_pulse_sequencer_unit.sv @@
// Top level of the servo pulse sequencer.
//
// in channel (in_valid/in_ready/in_data): a timer tick or a received command
// byte. out channel (out_valid/out_ready/out_data): result items, the final
// one of each input marked by last. Ticks and plain bytes give one result,
// '+' and '-' give four (echo, CR, LF, '>').
// An input is handled in the cycle it transfers; its first result shows on
// out the next cycle. One-result items run at one per cycle, back to back,
// as the next input transfers in the cycle the last result of the previous
// one transfers. A '+' or '-' holds in_ready low until its final '>'
// result transfers from the output register.
// A config write (cfg_we, cfg_index, cfg_wdata) holds in_ready low for the
// following cycle while the per-degree step is rederived by a reciprocal
// multiply; the same holds for the first cycle after reset.
// Reset sets calibration to 780/2200, all angles to -90, all pulse widths to
// 780, selected and active channel to 0 and empties the output register.
// When out_ready is low the pending result holds and no input is taken.
`timescale 1ns / 1ps
`include "servo_pulse_sequencer_unit_macros.svh"
module servo_pulse_sequencer_unit
  import spsu_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  spsu_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output spsu_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  spsu_scale_t scale;
  spsu_burst_t burst;
  logic        accept;
  logic        out_last;

  assign in_ready = !scale.busy && (!out_valid || (out_ready && out_last));
  assign accept   = in_valid && in_ready;

  spsu_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .scale     (scale)
  );

  spsu_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .scale   (scale),
    .burst   (burst)
  );

  spsu_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst_in  (burst),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .out_last  (out_last)
  );

  `SPSU_ASSERT_IMPLY(a_busy_blocks_in, clk, rst, scale.busy, !in_ready)
  `SPSU_ASSERT_IMPLY(a_no_take_mid_burst, clk, rst, out_valid && !out_data.last, !in_ready)
  `SPSU_ASSERT_IMPLY(a_lines_onehot, clk, rst, out_valid, $onehot(out_data.servo_lines))
  `SPSU_ASSERT_NEXT(a_transfer_gives_result, clk, rst, accept, out_valid)

endmodule

@@ design/spsu_scale.sv @@
// Calibration registers and derived midpoint and per-degree step.
`timescale 1ns / 1ps
module spsu_scale
  import spsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output spsu_scale_t scale
);

  logic [15:0] pulse_min;
  logic [15:0] pulse_max;
  logic        busy;
  logic [31:0] recip_prod;
  logic        diff_neg;
  logic signed [16:0] diff;
  logic [15:0] diff_mag;
  logic [8:0]  quot;
  logic [16:0] mid_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min <= PULSE_MIN_RESET;
      pulse_max <= PULSE_MAX_RESET;
      busy      <= 1'b1;
    end else begin
      busy <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PULSE_MIN: pulse_min <= cfg_wdata;
          CFG_PULSE_MAX: pulse_max <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign diff     = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
  assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];

  // |max - min| / 180 by reciprocal, truncated toward zero
  always_ff @(posedge clk) begin
    recip_prod <= diff_mag * RECIP_180;
    diff_neg   <= diff[16];
  end

  assign quot    = recip_prod[31:RECIP_SHIFT];
  assign mid_sum = {1'b0, pulse_min} + {1'b0, pulse_max};

  always_comb begin
    scale.busy = busy;
    scale.step = diff_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    scale.mid  = mid_sum[16:1];
  end

endmodule

@@ design/spsu_core.sv @@
// Channel tables, tick sequencing and command decode.
`timescale 1ns / 1ps
module spsu_core
  import spsu_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  spsu_in_t    in_data,
  input  spsu_scale_t scale,
  output spsu_burst_t burst
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  logic signed [7:0] channel_angle [CHANNELS];
  logic [15:0]       channel_pulse [CHANNELS];
  logic [CH_W-1:0]   selected_channel;
  logic [CH_W-1:0]   active_channel;
  logic [15:0]       tick_count;

  logic [CH_W-1:0]   active_next;
  logic              wrap;
  logic [7:0]        ch;
  logic              is_digit;
  logic [7:0]        digit;
  logic              digit_ok;
  logic              is_step;
  logic signed [8:0] ang_sum;
  logic signed [7:0] angle_next;
  logic signed [17:0] offset;
  logic signed [18:0] pulse_sum;
  logic [15:0]       pulse_next;

  assign ch       = in_data.rx_byte;
  assign is_digit = (ch >= CHAR_ONE) && (ch <= CHAR_EIGHT);
  assign digit    = ch - CHAR_ONE;
  assign digit_ok = is_digit && (int'(digit[2:0]) < CHANNELS);
  assign is_step  = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);

  assign wrap        = tick_count >= channel_pulse[active_channel];
  assign active_next = (active_channel == LAST_CH) ? '0 : active_channel + 1'b1;

  always_comb begin
    if (ch == CHAR_PLUS) begin
      ang_sum    = 9'(channel_angle[selected_channel]) + 9'(ANGLE_STEP);
      angle_next = (ang_sum > 9'(ANGLE_MAX)) ? ANGLE_MAX : ang_sum[7:0];
    end else begin
      ang_sum    = 9'(channel_angle[selected_channel]) - 9'(ANGLE_STEP);
      angle_next = (ang_sum < 9'(ANGLE_MIN)) ? ANGLE_MIN : ang_sum[7:0];
    end
    offset    = 18'(angle_next) * 18'(scale.step);
    pulse_sum = $signed({3'b000, scale.mid}) + 19'(offset);
    if (pulse_sum < 0) begin
      pulse_next = '0;
    end else if (pulse_sum > $signed(19'h0FFFF)) begin
      pulse_next = 16'hFFFF;
    end else begin
      pulse_next = pulse_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        channel_angle[i] <= ANGLE_MIN;
        channel_pulse[i] <= PULSE_MIN_RESET;
      end
      selected_channel <= '0;
      active_channel   <= '0;
      tick_count       <= '0;
    end else if (accept) begin
      if (in_data.req_type == REQ_TICK) begin
        if (wrap) begin
          active_channel <= active_next;
          tick_count     <= '0;
        end else begin
          tick_count <= tick_count + 16'd1;
        end
      end else if (digit_ok) begin
        selected_channel <= CH_W'(digit[2:0]);
      end else if (is_step) begin
        channel_angle[selected_channel] <= angle_next;
        channel_pulse[selected_channel] <= pulse_next;
      end
    end
  end

  always_comb begin
    burst.echo_byte = ch;
    if (in_data.req_type == REQ_TICK) begin
      burst.kind   = KIND_TICK;
      burst.active = 3'(wrap ? active_next : active_channel);
    end else begin
      burst.kind   = is_step ? KIND_PROMPT : KIND_ECHO;
      burst.active = 3'(active_channel);
    end
  end

endmodule

@@ design/spsu_out.sv @@
// Result register that plays out the one or four results of an item.
`timescale 1ns / 1ps
module spsu_out
  import spsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  spsu_burst_t burst_in,
  output logic        out_valid,
  input  logic        out_ready,
  output spsu_out_t   out_data,
  output logic        out_last
);

  spsu_burst_t burst;
  logic        valid;
  logic [1:0]  beat;

  assign out_valid = valid;
  assign out_last  = (burst.kind != KIND_PROMPT) || (beat == BEAT_GT);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      beat  <= BEAT_ECHO;
    end else if (load) begin
      valid <= 1'b1;
      beat  <= BEAT_ECHO;
    end else if (valid && out_ready) begin
      if (out_last) begin
        valid <= 1'b0;
      end else begin
        beat <= beat + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

  always_comb begin
    out_data.tx_valid    = (burst.kind != KIND_TICK);
    out_data.servo_lines = 8'(9'd1 << burst.active);
    out_data.channel_odd = burst.active[0];
    out_data.last        = out_last;
    if (burst.kind == KIND_TICK) begin
      out_data.tx_byte = 8'h00;
    end else begin
      unique case (beat)
        BEAT_ECHO: out_data.tx_byte = burst.echo_byte;
        BEAT_CR:   out_data.tx_byte = CHAR_CR;
        BEAT_LF:   out_data.tx_byte = CHAR_LF;
        BEAT_GT:   out_data.tx_byte = CHAR_GT;
        default:   out_data.tx_byte = burst.echo_byte;
      endcase
    end
  end

endmodule
